>>> rtl/arm64_integer_alu_regfile_macros.svh
// Assertion macros shared by the integer ALU RTL.
// Defining ASSERT_OFF turns every macro use into empty text.
`ifndef ARM64_INTEGER_ALU_REGFILE_MACROS_SVH
`define ARM64_INTEGER_ALU_REGFILE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge of aclk, skipped while aresetn is low.
`define A64_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every rising edge of aclk, including reset cycles.
`define A64_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define A64_ASSERT(lbl, prop, msg)
`define A64_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/a64alu_pkg.sv
// Types, operation codes and helper functions for the integer ALU with register file.
// Used by a64alu_regfile, arm64_integer_alu_regfile and the testbench; depends on nothing.
package a64alu_pkg;

    localparam int NUM_REGS = 32;
    localparam int REG_W    = 5;
    localparam int DATA_W   = 64;
    localparam int HALF_W   = 32;
    localparam int ACT_W    = 3;
    localparam int IMM_W    = 12;
    localparam int SHIFT_W  = 2;
    localparam int IMM_SHIFT_AMT = 12;
    localparam int IMM_EXT_W = IMM_W + IMM_SHIFT_AMT;

    // Operation codes carried on the input tuser.
    localparam logic [ACT_W-1:0] ACT_ADD_REG  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADDS_REG = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD_IMM  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ADDS_IMM = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SUBS_REG = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SUBS_IMM = 3'd5;
    localparam logic [ACT_W-1:0] ACT_MUL      = 3'd6;
    localparam logic [ACT_W-1:0] ACT_LOAD     = 3'd7;

    // Register number whose SUBS write is dropped (the CMP alias).
    localparam logic [REG_W-1:0] ZERO_REG = 5'd31;
    // Shift code that moves the immediate up by twelve bits.
    localparam logic [SHIFT_W-1:0] SHIFT_LSL12 = 2'd1;

    typedef logic [REG_W-1:0]  reg_idx_t;
    typedef logic [DATA_W-1:0] word_t;
    typedef logic [ACT_W-1:0]  act_t;

    // Read request to the register file; read data is registered and appears in the cycle after the request.
    typedef struct packed {
        logic     en;
        reg_idx_t addr_a;
        reg_idx_t addr_b;
    } rf_rd_t;

    // Write request to the register file.
    typedef struct packed {
        logic     en;
        reg_idx_t addr;
        word_t    data;
    } rf_wr_t;

    // Builds the zero-extended immediate operand.
    function automatic logic [IMM_EXT_W-1:0] make_imm(input logic [IMM_W-1:0] imm,
                                                      input logic [SHIFT_W-1:0] shift);
        logic [IMM_EXT_W-1:0] v;
        v = {{IMM_SHIFT_AMT{1'b0}}, imm};
        if (shift == SHIFT_LSL12) begin
            v = {imm, {IMM_SHIFT_AMT{1'b0}}};
        end
        return v;
    endfunction

    // True for the forms that update N and Z.
    function automatic logic sets_flags(input act_t act);
        return (act == ACT_ADDS_REG) || (act == ACT_ADDS_IMM) ||
               (act == ACT_SUBS_REG) || (act == ACT_SUBS_IMM);
    endfunction

    // True for the subtract forms.
    function automatic logic is_subs(input act_t act);
        return (act == ACT_SUBS_REG) || (act == ACT_SUBS_IMM);
    endfunction

    // True for the forms whose second operand is the immediate.
    function automatic logic is_imm_form(input act_t act);
        return (act == ACT_ADD_IMM) || (act == ACT_ADDS_IMM) || (act == ACT_SUBS_IMM);
    endfunction

endpackage

>>> rtl/a64alu_regfile.sv
// 32 x 64-bit register file: one write port and two read ports with registered data.
// Depends on a64alu_pkg for the request structs and word type.
module a64alu_regfile (
    input  logic              aclk,
    input  a64alu_pkg::rf_rd_t rd_req,
    input  a64alu_pkg::rf_wr_t wr_req,
    output a64alu_pkg::word_t  rdata_a,
    output a64alu_pkg::word_t  rdata_b
);

    a64alu_pkg::word_t mem [a64alu_pkg::NUM_REGS];
    a64alu_pkg::word_t rdata_a_reg;
    a64alu_pkg::word_t rdata_b_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_req.addr] <= wr_req.data;
        end
    end

    // Two read ports; data is held until the next read request.
    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rdata_a_reg <= mem[rd_req.addr_a];
            rdata_b_reg <= mem[rd_req.addr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/arm64_integer_alu_regfile.sv
// Channel  Direction  Ports                      Contents
// s_       in         tvalid tready tdata tuser  instruction: operands, immediate, load value
// m_       out        tvalid tready tdata        result value, N, Z, write indication
//
// Add, add-immediate, subtract and load pass through the execute and write-back steps;
// MUL adds the MUL1 and MUL2 steps, since the 64-bit product is built from three 32 x 32
// partial products on one shared multiplier. One instruction is in flight at a time, so a
// register write always lands before the next instruction reads the register file.
// A finished result waits in the output register while the next instruction is taken;
// a stalled output holds the write-back step. Reset clears the control state and flags.
//
// Top level of the integer ALU; depends on a64alu_pkg, a64alu_regfile and the macro header.
`include "arm64_integer_alu_regfile_macros.svh"

module arm64_integer_alu_regfile (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Bits from 0 up: dest_reg[4:0], src_a_reg[9:5], src_b_reg[14:10], imm_value[26:15],
    // imm_shift[28:27], load_value[92:29], zero fill[95:93].
    input  logic [95:0] s_tdata,
    // Bits from 0 up: action[2:0].
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Bits from 0 up: result_value[63:0], flag_negative[64], flag_zero[65],
    // reg_written[66], zero fill[71:67].
    output logic [71:0] m_tdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_MUL2  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    localparam int HW = a64alu_pkg::HALF_W;
    localparam int DW = a64alu_pkg::DATA_W;

    // Control state.
    logic [2:0] state_reg, state_next;
    logic       n_flag_reg, n_flag_next;
    logic       z_flag_reg, z_flag_next;
    logic       m_valid_reg, m_valid_next;

    // Instruction payload held for the whole execution.
    a64alu_pkg::act_t     act_reg;
    a64alu_pkg::reg_idx_t dest_idx_reg;
    logic [a64alu_pkg::IMM_EXT_W-1:0] imm_reg;
    a64alu_pkg::word_t    load_val_reg;

    // Datapath registers.
    a64alu_pkg::word_t res_reg, res_next;
    logic [HW-1:0]     acc_reg, acc_next;
    a64alu_pkg::word_t out_data_reg;
    logic              out_n_reg, out_z_reg, out_wr_reg;

    a64alu_pkg::rf_rd_t rf_rd;
    a64alu_pkg::rf_wr_t rf_wr;
    a64alu_pkg::word_t  rdata_a, rdata_b;

    logic              s_accept;
    logic              out_free;
    logic              write_fire;
    logic              cmp_form;
    logic              flag_upd;
    logic              res_n, res_z;
    a64alu_pkg::word_t opb;
    a64alu_pkg::word_t sum, diff;
    logic [HW-1:0]     mul_x, mul_y;
    logic [DW-1:0]     prod;
    logic [HW-1:0]     cross_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Register file: read both sources when an instruction is taken.
    assign rf_rd.en     = s_accept;
    assign rf_rd.addr_a = s_tdata[9:5];
    assign rf_rd.addr_b = s_tdata[14:10];

    a64alu_regfile u_regfile (
        .aclk    (aclk),
        .rd_req  (rf_rd),
        .wr_req  (rf_wr),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Operand selection and the add and subtract paths.
    assign opb  = a64alu_pkg::is_imm_form(act_reg)
                ? {{(DW - a64alu_pkg::IMM_EXT_W){1'b0}}, imm_reg} : rdata_b;
    assign sum  = rdata_a + opb;
    assign diff = rdata_a - opb;

    // Shared 32 x 32 multiplier; the operand halves follow the step.
    always_comb begin
        mul_x = rdata_a[HW-1:0];
        mul_y = rdata_b[HW-1:0];
        case (state_reg)
            ST_MUL1: begin
                mul_y = rdata_b[DW-1:HW];
            end
            ST_MUL2: begin
                mul_x = rdata_a[DW-1:HW];
            end
            default: begin
            end
        endcase
    end
    assign prod      = mul_x * mul_y;
    assign cross_sum = acc_reg + prod[HW-1:0];

    // Write-back step conditions.
    assign out_free   = !m_valid_reg || m_tready;
    assign write_fire = (state_reg == ST_WRITE) && out_free;
    assign cmp_form   = a64alu_pkg::is_subs(act_reg) && (dest_idx_reg == a64alu_pkg::ZERO_REG);
    assign flag_upd   = write_fire && a64alu_pkg::sets_flags(act_reg);
    assign res_n      = res_reg[DW-1];
    assign res_z      = (res_reg == '0);

    assign rf_wr.en   = write_fire && !cmp_form;
    assign rf_wr.addr = dest_idx_reg;
    assign rf_wr.data = res_reg;

    // Sequencer and datapath next values.
    always_comb begin
        state_next  = state_reg;
        res_next    = res_reg;
        acc_next    = acc_reg;
        n_flag_next = n_flag_reg;
        z_flag_next = z_flag_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_WRITE;
                case (act_reg)
                    a64alu_pkg::ACT_SUBS_REG,
                    a64alu_pkg::ACT_SUBS_IMM: begin
                        res_next = diff;
                    end
                    a64alu_pkg::ACT_MUL: begin
                        res_next   = prod;
                        state_next = ST_MUL1;
                    end
                    a64alu_pkg::ACT_LOAD: begin
                        res_next = load_val_reg;
                    end
                    default: begin
                        res_next = sum;
                    end
                endcase
            end
            ST_MUL1: begin
                acc_next   = prod[HW-1:0];
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                res_next   = res_reg + {cross_sum, {HW{1'b0}}};
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (flag_upd) begin
            n_flag_next = res_n;
            z_flag_next = res_z;
        end
    end

    // The output register fills at write-back and empties on an output transfer.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (write_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_flag_reg  <= 1'b0;
            z_flag_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_flag_reg  <= n_flag_next;
            z_flag_reg  <= z_flag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg      <= s_tuser;
            dest_idx_reg <= s_tdata[4:0];
            imm_reg      <= a64alu_pkg::make_imm(s_tdata[26:15], s_tdata[28:27]);
            load_val_reg <= s_tdata[92:29];
        end
        res_reg <= res_next;
        acc_reg <= acc_next;
        if (write_fire) begin
            out_data_reg <= res_reg;
            out_n_reg    <= flag_upd ? res_n : n_flag_reg;
            out_z_reg    <= flag_upd ? res_z : z_flag_reg;
            out_wr_reg   <= !cmp_form;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_wr_reg, out_z_reg, out_n_reg, out_data_reg};

    `A64_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE) && !m_valid_reg, "reset did not return to idle with an empty output")
    `A64_ASSERT(a_accept_exec, s_accept |=> state_reg == ST_EXEC, "accepted instruction did not enter execution")
    `A64_ASSERT(a_write_valid, rf_wr.en |=> m_valid_reg, "register write without a result in the output register")
    `A64_ASSERT(a_cmp_no_write, (state_reg == ST_WRITE) && cmp_form |-> !rf_wr.en, "compare form wrote the register file")
    `A64_ASSERT(a_n_hold, !flag_upd |=> $stable(n_flag_reg), "N flag changed without a flag-setting write-back")
    `A64_ASSERT(a_z_hold, !flag_upd |=> $stable(z_flag_reg), "Z flag changed without a flag-setting write-back")

endmodule

>>> verif/tb_arm64_integer_alu_regfile.sv
// Self-checking testbench for the integer ALU with its 32-entry register file.
// Depends on a64alu_pkg and the arm64_integer_alu_regfile RTL; it predicts every result
// in SystemVerilog and checks each output transfer against the oldest prediction.
module tb_arm64_integer_alu_regfile;
    timeunit 1ns;
    timeprecision 1ps;

    import a64alu_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_CHUNK   = 275;

    // One instruction as the testbench sees it.
    typedef struct {
        act_t                 action;
        reg_idx_t             dest;
        reg_idx_t             src_a;
        reg_idx_t             src_b;
        logic [IMM_W-1:0]     imm_value;
        logic [SHIFT_W-1:0]   imm_shift;
        word_t                load_value;
    } alu_instr_t;

    // One result as carried on the output channel.
    typedef struct {
        word_t value;
        logic  neg;
        logic  zero;
        logic  written;
    } alu_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    // Predictor state: a copy of the register file and the flags.
    word_t       rf_model [NUM_REGS];
    logic        flag_n = 1'b0;
    logic        flag_z = 1'b0;

    alu_result_t pending_results [$];
    int          error_count  = 0;
    int          result_count = 0;
    int          burst_left   = 0;
    int          idle_cycles  = 0;
    int          stall_left   = 0;
    int          stall_mode   = 0;

    arm64_integer_alu_regfile dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("ERROR at %0t: result %0d %s: got %h, expected %h",
                 $realtime, result_count, what, got, want);
    endtask

    // Executes one instruction on the predictor state and returns its result.
    function automatic alu_result_t execute_instr(input alu_instr_t ins);
        alu_result_t res;
        word_t       op_a;
        word_t       op_b;
        word_t       imm_ext;
        logic        sets;
        op_a    = rf_model[ins.src_a];
        op_b    = rf_model[ins.src_b];
        imm_ext = word_t'(ins.imm_value);
        if (ins.imm_shift == SHIFT_LSL12) begin
            imm_ext = imm_ext << IMM_SHIFT_AMT;
        end
        sets        = 1'b0;
        res.written = 1'b1;
        case (ins.action)
            ACT_ADD_REG: begin
                res.value = op_a + op_b;
            end
            ACT_ADDS_REG: begin
                res.value = op_a + op_b;
                sets      = 1'b1;
            end
            ACT_ADD_IMM: begin
                res.value = op_a + imm_ext;
            end
            ACT_ADDS_IMM: begin
                res.value = op_a + imm_ext;
                sets      = 1'b1;
            end
            ACT_SUBS_REG: begin
                res.value   = op_a - op_b;
                sets        = 1'b1;
                res.written = (ins.dest != ZERO_REG);
            end
            ACT_SUBS_IMM: begin
                res.value   = op_a - imm_ext;
                sets        = 1'b1;
                res.written = (ins.dest != ZERO_REG);
            end
            ACT_MUL: begin
                res.value = op_a * op_b;
            end
            default: begin
                res.value = ins.load_value;
            end
        endcase
        if (sets) begin
            flag_n = res.value[DATA_W-1];
            flag_z = (res.value == '0);
        end
        if (res.written) begin
            rf_model[ins.dest] = res.value;
        end
        res.neg  = flag_n;
        res.zero = flag_z;
        return res;
    endfunction

    // Operand values biased toward the corners and toward small numbers.
    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(DATA_W-1){1'b0}}};
            3:       return {1'b0, {(DATA_W-1){1'b1}}};
            4, 5:    return word_t'($urandom_range(0, 4096));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Sends one instruction; bursts of random length are separated by random gaps.
    task automatic send_instr(input act_t act, input reg_idx_t dest, input reg_idx_t src_a,
                              input reg_idx_t src_b, input logic [IMM_W-1:0] imm,
                              input logic [SHIFT_W-1:0] shift, input word_t load_value);
        alu_instr_t ins;
        int         gap;
        ins = '{act, dest, src_a, src_b, imm, shift, load_value};
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {3'b000, ins.load_value, ins.imm_shift, ins.imm_value,
                     ins.src_b, ins.src_a, ins.dest};
        s_tuser  <= ins.action;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(execute_instr(ins));
    endtask

    // Holds the input side off until every predicted result has been seen.
    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Loads every register, so that no later read touches an unwritten entry.
    task automatic test_register_init();
        word_t    value;
        reg_idx_t src;
        for (int i = 0; i < NUM_REGS; i++) begin
            case (i)
                0:       value = '0;
                1:       value = 64'd1;
                2:       value = '1;
                3:       value = {1'b1, {(DATA_W-1){1'b0}}};
                4:       value = {1'b0, {(DATA_W-1){1'b1}}};
                5:       value = 64'd4095;
                6:       value = 64'd4095 << IMM_SHIFT_AMT;
                default: value = pick_word();
            endcase
            src = (i == 0) ? reg_idx_t'(0) : reg_idx_t'($urandom_range(0, i - 1));
            send_instr(ACT_LOAD, reg_idx_t'(i), src, src, '0, '0, value);
        end
    endtask

    // Add forms: wrap to zero, sign change, all shift codes, write to register 31.
    task automatic test_add_forms();
        send_instr(ACT_ADD_REG,  5'd10, 5'd2, 5'd1, '0,       2'd0, '0);
        send_instr(ACT_ADDS_REG, 5'd11, 5'd2, 5'd1, '0,       2'd0, '0);
        send_instr(ACT_ADDS_REG, 5'd12, 5'd4, 5'd1, '0,       2'd0, '0);
        send_instr(ACT_ADD_IMM,  5'd13, 5'd0, 5'd3, 12'hFFF,  2'd0, '0);
        send_instr(ACT_ADDS_IMM, 5'd14, 5'd2, 5'd3, 12'h001,  2'd0, '0);
        send_instr(ACT_ADDS_IMM, 5'd15, 5'd0, 5'd3, 12'hFFF,  SHIFT_LSL12, '0);
        send_instr(ACT_ADD_IMM,  5'd16, 5'd4, 5'd3, 12'hFFF,  2'd2, '0);
        send_instr(ACT_ADDS_IMM, 5'd17, 5'd6, 5'd3, 12'h000,  2'd3, '0);
        send_instr(ACT_ADD_REG,  ZERO_REG, 5'd5, 5'd6, '0,    2'd0, '0);
    endtask

    // Subtract forms, including the compare alias that drops its write.
    task automatic test_subtract_forms();
        send_instr(ACT_SUBS_REG, 5'd18,    5'd0, 5'd1, '0,      2'd0, '0);
        send_instr(ACT_SUBS_REG, ZERO_REG, 5'd5, 5'd5, '0,      2'd0, '0);
        // Register 31 must still hold the sum written above.
        send_instr(ACT_ADD_IMM,  5'd19,    ZERO_REG, 5'd0, '0,  2'd0, '0);
        send_instr(ACT_SUBS_IMM, 5'd20,    5'd3, 5'd0, 12'h001, 2'd0, '0);
        send_instr(ACT_SUBS_IMM, ZERO_REG, 5'd6, 5'd0, 12'hFFF, SHIFT_LSL12, '0);
        send_instr(ACT_SUBS_IMM, 5'd21,    5'd5, 5'd0, 12'hFFF, 2'd0, '0);
        send_instr(ACT_SUBS_REG, 5'd22,    5'd3, 5'd4, '0,      2'd0, '0);
    endtask

    // Multiply: low 64 bits of products that overflow.
    task automatic test_multiply();
        send_instr(ACT_MUL, 5'd23,    5'd2, 5'd2, '0, 2'd0, '0);
        send_instr(ACT_MUL, 5'd24,    5'd3, 5'd3, '0, 2'd0, '0);
        send_instr(ACT_MUL, 5'd25,    5'd4, 5'd4, '0, 2'd0, '0);
        send_instr(ACT_MUL, ZERO_REG, 5'd2, 5'd4, '0, 2'd0, '0);
    endtask

    // Loads leave the flags as they stand; register 31 is ordinary storage for loads.
    task automatic test_load_and_flags();
        send_instr(ACT_ADDS_REG, 5'd26,    5'd3, 5'd3, '0, 2'd0, '0);
        send_instr(ACT_LOAD,     ZERO_REG, 5'd0, 5'd1, '0, 2'd0,
                   {1'b0, {(DATA_W-1){1'b1}}});
        send_instr(ACT_ADD_REG,  5'd27,    ZERO_REG, 5'd1, '0, 2'd0, '0);
        send_instr(ACT_LOAD,     5'd0,     5'd27, 5'd26, 12'hFFF, 2'd3,
                   {1'b1, {(DATA_W-1){1'b0}}});
    endtask

    // Random instructions with fully random fields; some SUBS register forms get equal operands for zero results.
    task automatic test_random_stream(input int count);
        act_t                act;
        reg_idx_t            dest;
        reg_idx_t            src_a;
        reg_idx_t            src_b;
        logic [IMM_W-1:0]    imm;
        logic [SHIFT_W-1:0]  shift;
        for (int i = 0; i < count; i++) begin
            act   = act_t'($urandom_range(0, 7));
            dest  = reg_idx_t'($urandom);
            src_a = reg_idx_t'($urandom);
            src_b = reg_idx_t'($urandom);
            imm   = IMM_W'($urandom);
            shift = SHIFT_W'($urandom);
            if (act == ACT_SUBS_REG && $urandom_range(0, 3) == 0) begin
                src_b = src_a;
            end
            send_instr(act, dest, src_a, src_b, imm, shift, pick_word());
        end
        drain_results();
    endtask

    // Output side: stall pattern that changes between steady, random and full stalls.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 15) : $urandom_range(8, 120);
        end
        stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= 1'b0;
        endcase
    end

    // Checks every output transfer against the oldest prediction.
    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata[63:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[63:0] !== want.value) begin
                    report_mismatch("result_value", m_tdata[63:0], want.value);
                end
                if (m_tdata[64] !== want.neg) begin
                    report_mismatch("flag_negative", 64'(m_tdata[64]), 64'(want.neg));
                end
                if (m_tdata[65] !== want.zero) begin
                    report_mismatch("flag_zero", 64'(m_tdata[65]), 64'(want.zero));
                end
                if (m_tdata[66] !== want.written) begin
                    report_mismatch("reg_written", 64'(m_tdata[66]), 64'(want.written));
                end
            end
            result_count++;
        end
    end

    // Ends the run when no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired at %0t with %0d results outstanding",
                     $realtime, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_register_init();
        test_add_forms();
        test_subtract_forms();
        test_multiply();
        test_load_and_flags();
        drain_results();
        for (int chunk = 0; chunk < 4; chunk++) begin
            test_random_stream(RANDOM_CHUNK);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never seen", 64'(pending_results.size()), '0);
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
